// File: src/ora_pkg.sv
// package: types, constants and helpers for the obstacle repulsion accumulator
package ora_pkg;

    localparam int CORDIC_ITERATIONS = 16;

    localparam logic [1:0] CFG_RANGE    = 2'd0;
    localparam logic [1:0] CFG_GAIN     = 2'd1;
    localparam logic [1:0] CFG_EXPONENT = 2'd2;

    localparam logic [15:0] RANGE_RESET    = 16'd8192;
    localparam logic [15:0] GAIN_RESET     = 16'd256;
    localparam logic [2:0]  EXPONENT_RESET = 3'd2;

    localparam logic signed [33:0] CORDIC_START = 34'sh026DD3B6A;
    localparam logic signed [33:0] HALF_TURN    = 34'sh080000000;
    localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_RP,
        ST_MUL,
        ST_CORDIC,
        ST_MZ,
        ST_MX,
        ST_SQZ,
        ST_SQX,
        ST_SQRT,
        ST_VEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [15:0]        obstacle_distance;
        logic signed [15:0] obstacle_angle;
        logic [15:0]        goal_distance;
        logic               last_reading;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sum_z;
        logic signed [31:0] sum_x;
        logic [30:0]        magnitude;
        logic signed [15:0] direction;
        logic               overflow;
    } t_out_item;

    function automatic logic [29:0] atan_unit(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41721;
            5'd15: v = 30'd20860;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2607;
            5'd19: v = 30'd1303;
            5'd20: v = 30'd651;
            5'd21: v = 30'd325;
            5'd22: v = 30'd162;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // bit 32 flags saturation, bits 31:0 hold the clamped sum
    function automatic logic [32:0] sat_add(input logic signed [31:0] acc,
                                            input logic signed [35:0] add);
        logic signed [35:0] t;
        logic [32:0]        r;
        t = 36'(acc) + add;
        if (t > 36'sh07FFFFFFF) begin
            r = {1'b1, 32'h7FFFFFFF};
        end else if (t < -36'sh080000000) begin
            r = {1'b1, 32'h80000000};
        end else begin
            r = {1'b0, t[31:0]};
        end
        return r;
    endfunction

endpackage

// File: src/obstacle_repulsion_accumulator_core.sv
// top level: obstacle repulsion accumulator with shared serial arithmetic
// A reading is taken in, then the two reciprocals are formed (a restoring divider that
// produces one quotient bit per cycle, 29 bits each), then the 3 + e products of the
// magnitude chain (a shift-add multiplier taking one multiplier bit per cycle, e being the
// goal exponent in use, at most 7), the sin/cos rotation CORDIC and the two components. A
// last-of-scan reading adds the squaring, the square root, the vectoring CORDIC and a step
// to register the result; the next reading is taken while that result waits in the output
// register, but a result that finishes while the previous one is still held stalls the input
// until the output register is free. A reading beyond the influence range needs no further
// work unless it closes the scan.
module obstacle_repulsion_accumulator_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ora_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ora_pkg::t_out_item    o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    ora_pkg::t_state n_state;
    ora_pkg::t_state r_state;

    logic [15:0] r_range;
    logic [15:0] r_gain;
    logic [2:0]  r_exp;

    logic [15:0] r_d;
    logic [15:0] r_g;
    logic [15:0] r_ang;
    logic        r_last;
    logic [3:0]  r_nmul;
    logic [3:0]  r_step;
    logic [4:0]  r_cnt;

    logic [16:0] r_rem;
    logic [28:0] r_q;
    logic [31:0] r_rd;
    logic [31:0] r_m;

    logic [63:0]        r_ma;
    logic [31:0]        r_mb;
    logic signed [65:0] r_prod;

    logic signed [33:0] r_cx;
    logic signed [33:0] r_cy;
    logic signed [33:0] r_cz;
    logic               r_flip;

    logic [63:0] r_sq;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic [30:0] r_mag;
    logic        r_mag_ovf;

    logic signed [49:0] r_vx;
    logic signed [49:0] r_vy;
    logic signed [33:0] r_vang;
    logic               r_zero;

    logic signed [31:0] r_acc_z;
    logic signed [31:0] r_acc_x;
    logic               r_sat;

    logic               r_out_valid;
    ora_pkg::t_out_item r_out;

    logic               in_accept;
    logic               in_range;
    logic               cnt_last;
    logic               cordic_last;
    logic               out_free;
    logic [15:0]        div_v;
    logic [16:0]        div_sh;
    logic               div_ge;
    logic [28:0]        div_q;
    logic [31:0]        recip;
    logic               mul_signed;
    logic signed [65:0] addend;
    logic signed [65:0] mul_next;
    logic [31:0]        qm;
    logic               qm_sat;
    logic [3:0]         step_next;
    logic [31:0]        mul_op;
    logic signed [33:0] cx_sh;
    logic signed [33:0] cy_sh;
    logic signed [33:0] cx_next;
    logic signed [33:0] cy_next;
    logic signed [33:0] cz_next;
    logic signed [33:0] z_init;
    logic signed [49:0] vx_sh;
    logic signed [49:0] vy_sh;
    logic signed [49:0] vx_init;
    logic signed [49:0] vy_init;
    logic [32:0]        sum_new;
    logic [31:0]        abs_z;
    logic [31:0]        abs_x;
    logic [63:0]        sq_t;
    logic [63:0]        root_next;
    logic signed [33:0] dir_sum;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_range    = i_in_data.obstacle_distance <= r_range;
    assign cnt_last    = r_cnt == 5'd31;
    assign cordic_last = r_cnt == 5'(ora_pkg::CORDIC_ITERATIONS - 1);
    assign out_free    = !r_out_valid || !i_out_stall;

    // reciprocal 2^28 / v, one quotient bit per cycle
    assign div_v  = (r_state == ora_pkg::ST_RP) ? r_range : r_d;
    assign div_sh = {r_rem[15:0], (r_cnt == 5'd0)};
    assign div_ge = div_sh >= {1'b0, div_v};
    assign div_q  = {r_q[27:0], div_ge};
    assign recip  = (div_v == 16'd0) ? 32'hFFFFFFFF : {3'b000, div_q};

    // shift-add multiplier, sign bit of the multiplier weighs negative in signed mode
    assign mul_signed = (r_state == ora_pkg::ST_MZ) || (r_state == ora_pkg::ST_MX);
    assign addend     = r_mb[0] ? $signed({2'b00, r_ma}) : 66'sd0;
    assign mul_next   = (mul_signed && cnt_last) ? r_prod - addend : r_prod + addend;
    assign qm_sat     = mul_next[63:48] != 16'd0;
    assign qm         = qm_sat ? 32'hFFFFFFFF : mul_next[47:16];
    assign step_next  = r_step + 4'd1;

    always_comb begin
        case (step_next)
            4'd1:    mul_op = r_rd;
            4'd2:    mul_op = {8'd0, r_gain, 8'd0};
            default: mul_op = {12'd0, r_g, 4'd0};
        endcase
    end

    // rotation cordic
    assign cx_sh = r_cx >>> r_cnt;
    assign cy_sh = r_cy >>> r_cnt;
    always_comb begin
        if (r_cz >= 0) begin
            cx_next = r_cx - cy_sh;
            cy_next = r_cy + cx_sh;
            cz_next = r_cz - $signed({4'd0, ora_pkg::atan_unit(r_cnt)});
        end else begin
            cx_next = r_cx + cy_sh;
            cy_next = r_cy - cx_sh;
            cz_next = r_cz + $signed({4'd0, ora_pkg::atan_unit(r_cnt)});
        end
    end
    assign z_init = {{2{r_ang[15]}}, r_ang, 16'd0};

    // vectoring cordic
    assign vx_sh   = r_vx >>> r_cnt;
    assign vy_sh   = r_vy >>> r_cnt;
    assign vx_init = {{2{r_acc_x[31]}}, r_acc_x, 16'd0};
    assign vy_init = {{2{r_acc_z[31]}}, r_acc_z, 16'd0};

    assign sum_new = ora_pkg::sat_add(
        (r_state == ora_pkg::ST_MZ) ? r_acc_z : r_acc_x, mul_next[65:30]);
    assign abs_z   = r_acc_z[31] ? 32'(-r_acc_z) : r_acc_z;
    assign abs_x   = r_acc_x[31] ? 32'(-r_acc_x) : r_acc_x;

    assign sq_t      = r_root + r_bit;
    assign root_next = (r_sq >= sq_t) ? (r_root >> 1) + r_bit : r_root >> 1;
    assign dir_sum   = r_vang + 34'sd32768;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ora_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (in_range) begin
                        n_state = ora_pkg::ST_RD;
                    end else if (i_in_data.last_reading) begin
                        n_state = ora_pkg::ST_SQZ;
                    end
                end
            end
            ora_pkg::ST_RD: begin
                if (r_cnt == 5'd28) n_state = ora_pkg::ST_RP;
            end
            ora_pkg::ST_RP: begin
                if (r_cnt == 5'd28) n_state = ora_pkg::ST_MUL;
            end
            ora_pkg::ST_MUL: begin
                if (cnt_last && step_next == r_nmul) n_state = ora_pkg::ST_CORDIC;
            end
            ora_pkg::ST_CORDIC: begin
                if (cordic_last) n_state = ora_pkg::ST_MZ;
            end
            ora_pkg::ST_MZ: begin
                if (cnt_last) n_state = ora_pkg::ST_MX;
            end
            ora_pkg::ST_MX: begin
                if (cnt_last) n_state = r_last ? ora_pkg::ST_SQZ : ora_pkg::ST_IDLE;
            end
            ora_pkg::ST_SQZ: begin
                if (cnt_last) n_state = ora_pkg::ST_SQX;
            end
            ora_pkg::ST_SQX: begin
                if (cnt_last) n_state = ora_pkg::ST_SQRT;
            end
            ora_pkg::ST_SQRT: begin
                if (cnt_last) n_state = ora_pkg::ST_VEC;
            end
            ora_pkg::ST_VEC: begin
                if (cordic_last) n_state = ora_pkg::ST_DONE;
            end
            ora_pkg::ST_DONE: begin
                if (out_free) n_state = ora_pkg::ST_IDLE;
            end
            default: n_state = ora_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = r_state != ora_pkg::ST_IDLE;
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ora_pkg::ST_IDLE;
            r_range     <= ora_pkg::RANGE_RESET;
            r_gain      <= ora_pkg::GAIN_RESET;
            r_exp       <= ora_pkg::EXPONENT_RESET;
            r_acc_z     <= '0;
            r_acc_x     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ora_pkg::CFG_RANGE:    r_range <= i_cfg_data;
                    ora_pkg::CFG_GAIN:     r_gain  <= i_cfg_data;
                    ora_pkg::CFG_EXPONENT: r_exp   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (r_state == ora_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ora_pkg::ST_MUL: begin
                    if (cnt_last && qm_sat) r_sat <= 1'b1;
                end
                ora_pkg::ST_MZ: begin
                    if (cnt_last) begin
                        r_acc_z <= sum_new[31:0];
                        if (sum_new[32]) r_sat <= 1'b1;
                    end
                end
                ora_pkg::ST_MX: begin
                    if (cnt_last) begin
                        r_acc_x <= sum_new[31:0];
                        if (sum_new[32]) r_sat <= 1'b1;
                    end
                end
                ora_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_acc_z     <= '0;
                        r_acc_x     <= '0;
                        r_sat       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ora_pkg::ST_IDLE: begin
                r_cnt  <= '0;
                r_rem  <= '0;
                r_d    <= i_in_data.obstacle_distance;
                r_g    <= i_in_data.goal_distance;
                r_ang  <= i_in_data.obstacle_angle;
                r_last <= i_in_data.last_reading;
                r_step <= '0;
                r_ma   <= {32'd0, abs_z};
                r_mb   <= abs_z;
                r_prod <= '0;
                if ({i_in_data.obstacle_distance, 1'b0} < {1'b0, r_range}) begin
                    r_nmul <= 4'd3 + {1'b0, r_exp};
                end else begin
                    r_nmul <= 4'd5;
                end
            end
            ora_pkg::ST_RD, ora_pkg::ST_RP: begin
                r_q <= div_q;
                if (r_cnt == 5'd28) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    if (r_state == ora_pkg::ST_RD) begin
                        r_rd <= recip;
                    end else begin
                        r_ma   <= {32'd0, r_rd - recip};
                        r_mb   <= r_rd;
                        r_prod <= '0;
                    end
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                    r_rem <= div_ge ? div_sh - {1'b0, div_v} : div_sh;
                end
            end
            ora_pkg::ST_MUL, ora_pkg::ST_MZ, ora_pkg::ST_MX,
            ora_pkg::ST_SQZ, ora_pkg::ST_SQX: begin
                r_cnt <= r_cnt + 5'd1;
                if (cnt_last) begin
                    r_prod <= '0;
                    case (r_state)
                        ora_pkg::ST_MUL: begin
                            r_m    <= qm;
                            r_step <= step_next;
                            r_ma   <= {32'd0, qm};
                            r_mb   <= mul_op;
                            r_cx   <= ora_pkg::CORDIC_START;
                            r_cy   <= '0;
                            if (z_init > ora_pkg::QUARTER_TURN) begin
                                r_cz   <= z_init - ora_pkg::HALF_TURN;
                                r_flip <= 1'b1;
                            end else if (z_init < -ora_pkg::QUARTER_TURN) begin
                                r_cz   <= z_init + ora_pkg::HALF_TURN;
                                r_flip <= 1'b1;
                            end else begin
                                r_cz   <= z_init;
                                r_flip <= 1'b0;
                            end
                        end
                        ora_pkg::ST_MZ: begin
                            r_ma <= {32'd0, r_m};
                            r_mb <= r_cx[31:0];
                        end
                        ora_pkg::ST_MX: begin
                            r_ma <= {32'd0, abs_z};
                            r_mb <= abs_z;
                        end
                        ora_pkg::ST_SQZ: begin
                            r_sq <= mul_next[63:0];
                            r_ma <= {32'd0, abs_x};
                            r_mb <= abs_x;
                        end
                        default: begin
                            r_sq   <= r_sq + mul_next[63:0];
                            r_root <= '0;
                            r_bit  <= 64'h4000000000000000;
                        end
                    endcase
                end else begin
                    r_prod <= mul_next;
                    r_ma   <= r_ma << 1;
                    r_mb   <= r_mb >> 1;
                end
            end
            ora_pkg::ST_CORDIC: begin
                r_cy <= cy_next;
                r_cz <= cz_next;
                if (cordic_last) begin
                    r_cnt  <= '0;
                    r_cx   <= r_flip ? -cx_next : cx_next;
                    r_ma   <= {32'd0, r_m};
                    r_mb   <= r_flip ? 32'(-cy_next) : cy_next[31:0];
                    r_prod <= '0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                    r_cx  <= cx_next;
                end
            end
            ora_pkg::ST_SQRT: begin
                r_cnt <= r_cnt + 5'd1;
                if (r_sq >= sq_t) r_sq <= r_sq - sq_t;
                r_root <= root_next;
                r_bit  <= r_bit >> 2;
                if (cnt_last) begin
                    r_mag_ovf <= root_next[63:31] != 33'd0;
                    r_mag     <= (root_next[63:31] != 33'd0) ? 31'h7FFFFFFF
                                                            : root_next[30:0];
                    r_zero    <= (r_acc_z == 32'sd0) && (r_acc_x == 32'sd0);
                    if (r_acc_x[31]) begin
                        r_vx   <= -vx_init;
                        r_vy   <= -vy_init;
                        r_vang <= ora_pkg::HALF_TURN;
                    end else begin
                        r_vx   <= vx_init;
                        r_vy   <= vy_init;
                        r_vang <= '0;
                    end
                end
            end
            ora_pkg::ST_VEC: begin
                r_cnt <= r_cnt + 5'd1;
                if (r_vy > 0) begin
                    r_vx   <= r_vx + vy_sh;
                    r_vy   <= r_vy - vx_sh;
                    r_vang <= r_vang + $signed({4'd0, ora_pkg::atan_unit(r_cnt)});
                end else begin
                    r_vx   <= r_vx - vy_sh;
                    r_vy   <= r_vy + vx_sh;
                    r_vang <= r_vang - $signed({4'd0, ora_pkg::atan_unit(r_cnt)});
                end
            end
            ora_pkg::ST_DONE: begin
                if (out_free) begin
                    r_out.sum_z     <= r_acc_z;
                    r_out.sum_x     <= r_acc_x;
                    r_out.magnitude <= r_mag;
                    r_out.direction <= r_zero ? 16'sd0 : dir_sum[31:16];
                    r_out.overflow  <= r_sat || r_mag_ovf;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ora_pkg::ST_IDLE) |-> o_in_stall)
        else $error("input taken while busy");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ora_pkg::ST_DONE && !r_out_valid) |=> o_out_valid)
        else $error("finished scan not registered");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ora_pkg::ST_DONE && !r_out_valid)
        |=> (r_acc_z == 32'sd0 && r_acc_x == 32'sd0 && !r_sat))
        else $error("sums not cleared after scan");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out))
        else $error("pending result overwritten");
`endif

endmodule

// File: tb/obstacle_repulsion_accumulator_core_tb.sv
// testbench: directed table and random range readings checked against a repulsion predictor or typed-in results
module obstacle_repulsion_accumulator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UQ_MAX = 64'hFFFFFFFF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int N_RANDOM = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    ora_pkg::t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    ora_pkg::t_out_item o_out_data;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = ora_pkg::CFG_RANGE;
    logic [15:0] i_cfg_data = '0;

    obstacle_repulsion_accumulator_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state and configuration
    logic [15:0] range_reg;
    logic [15:0] gain_reg;
    logic [2:0] expo_reg;
    logic signed [31:0] sum_z_acc;
    logic signed [31:0] sum_x_acc;
    bit flag_acc;

    ora_pkg::t_out_item scan_results[$];
    int errors = 0;
    int cycles = 0;
    bit idle_free = 1'b0;
    bit hold_rx = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint umul_sat(longint a, longint b);
        logic [127:0] p;
        logic [127:0] r;
        p = 128'(a) * 128'(b);
        r = p >> 16;
        if (r > 128'(UQ_MAX)) begin
            flag_acc = 1'b1;
            return UQ_MAX;
        end
        return longint'(r);
    endfunction

    function automatic longint inv_q(logic [15:0] v);
        if (v == 0) return UQ_MAX;
        return (64'd1 << 28) / v;
    endfunction

    function automatic longint arctan_step(int i);
        return longint'(ora_pkg::atan_unit(5'(i)));
    endfunction

    function automatic void rotate_bearing(logic [15:0] raw, output longint s,
                                           output longint c);
        longint z, x, y, nx;
        bit flip;
        z = longint'($signed(raw)) * 65536;
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; flip = 1'b1;
        end
        for (int i = 0; i < ora_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= arctan_step(i);
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += arctan_step(i);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [15:0] heading_of(logic signed [31:0] zs,
                                               logic signed [31:0] xs);
        longint y, x, nx, ang;
        logic [63:0] u;
        if (zs == 0 && xs == 0) return 16'd0;
        y = longint'(zs) * 65536;
        x = longint'(xs) * 65536;
        ang = 0;
        if (x < 0) begin
            x = -x; y = -y; ang = 64'sd2147483648;
        end
        for (int i = 0; i < ora_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
            if (y > 0) begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                ang += arctan_step(i);
            end else begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                ang -= arctan_step(i);
            end
            x = nx;
        end
        u = 64'(ang + 32768);
        return u[31:16];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_add(logic signed [31:0] acc, longint add);
        longint t;
        t = longint'(acc) + add;
        if (t > 64'sd2147483647) begin
            flag_acc = 1'b1; return 32'h7FFFFFFF;
        end
        if (t < -64'sd2147483648) begin
            flag_acc = 1'b1; return 32'h80000000;
        end
        return t[31:0];
    endfunction

    // returns 1 and fills res when the reading closes a scan
    function automatic bit predict_reading(ora_pkg::t_in_item it,
                                           output ora_pkg::t_out_item res);
        longint m, s, c, sz, sx;
        logic [63:0] msq, mag;
        int e;
        bit ovf;
        res = '0;
        if (it.obstacle_distance <= range_reg) begin
            m = inv_q(it.obstacle_distance) - inv_q(range_reg);
            m = umul_sat(m, inv_q(it.obstacle_distance));
            m = umul_sat(m, inv_q(it.obstacle_distance));
            m = umul_sat(m, longint'(gain_reg) << 8);
            e = (17'(it.obstacle_distance) * 2 < 17'(range_reg)) ? int'(expo_reg) : 2;
            for (int k = 0; k < e; k++)
                m = umul_sat(m, longint'(it.goal_distance) << 4);
            rotate_bearing(it.obstacle_angle, s, c);
            sum_z_acc = clamp_add(sum_z_acc, floor_shr(m * s, 30));
            sum_x_acc = clamp_add(sum_x_acc, floor_shr(m * c, 30));
        end
        if (!it.last_reading) return 1'b0;
        sz = longint'(sum_z_acc);
        sx = longint'(sum_x_acc);
        msq = 64'(sz * sz) + 64'(sx * sx);
        mag = int_sqrt(msq);
        ovf = flag_acc;
        if (mag > 64'h7FFFFFFF) begin
            mag = 64'h7FFFFFFF; ovf = 1'b1;
        end
        res.sum_z = sum_z_acc;
        res.sum_x = sum_x_acc;
        res.magnitude = mag[30:0];
        res.direction = heading_of(sum_z_acc, sum_x_acc);
        res.overflow = ovf;
        sum_z_acc = 0;
        sum_x_acc = 0;
        flag_acc = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    // receiver: random stall, long hold-off on request, no stall while idle_free is set
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else if (hold_rx) i_out_stall <= 1'b1;
        else if (idle_free) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < 25);
    end

    always @(posedge i_clk) begin
        ora_pkg::t_out_item w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scan_results.size() == 0) begin
                report_mismatch("unexpected transaction", longint'(o_out_data.sum_z),
                                64'sd0);
            end else begin
                w = scan_results.pop_front();
                if (o_out_data.sum_z !== w.sum_z)
                    report_mismatch("sum_z", longint'(o_out_data.sum_z),
                                    longint'(w.sum_z));
                if (o_out_data.sum_x !== w.sum_x)
                    report_mismatch("sum_x", longint'(o_out_data.sum_x),
                                    longint'(w.sum_x));
                if (o_out_data.magnitude !== w.magnitude)
                    report_mismatch("magnitude", longint'(o_out_data.magnitude),
                                    longint'(w.magnitude));
                if (o_out_data.direction !== w.direction)
                    report_mismatch("direction", longint'(o_out_data.direction),
                                    longint'(w.direction));
                if (o_out_data.overflow !== w.overflow)
                    report_mismatch("overflow", longint'(o_out_data.overflow),
                                    longint'(w.overflow));
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ora_pkg::CFG_RANGE: range_reg = val;
            ora_pkg::CFG_GAIN: gain_reg = val;
            default: expo_reg = val[2:0];
        endcase
    endtask

    task automatic drain_all();
        while (scan_results.size() != 0) @(posedge i_clk);
        // a reading with no result may still be busy after the queue has emptied
        repeat (600) @(posedge i_clk);
    endtask

    // drive one reading, wait for acceptance; expected result typed in or predicted
    task automatic send_reading(ora_pkg::t_in_item it, bit fixed,
                                ora_pkg::t_out_item fixed_res);
        ora_pkg::t_out_item r;
        bit has;
        @(negedge i_clk);
        while (!idle_free && $urandom_range(99) < 25) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        has = predict_reading(it, r);
        if (has) scan_results.push_back(fixed ? fixed_res : r);
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic ora_pkg::t_in_item mk(logic [15:0] d, logic [15:0] a,
                                             logic [15:0] g, bit l);
        ora_pkg::t_in_item it;
        it.obstacle_distance = d;
        it.obstacle_angle = a;
        it.goal_distance = g;
        it.last_reading = l;
        return it;
    endfunction

    function automatic ora_pkg::t_in_item random_reading(bit last);
        logic [15:0] d;
        case ($urandom_range(3))
            0: d = 16'($urandom_range(range_reg));
            1: d = 16'($urandom);
            2: d = 16'($urandom_range(range_reg / 2));
            default: d = range_reg;
        endcase
        return mk(d, 16'($urandom), ($urandom_range(3) == 0) ? 16'($urandom)
                  : 16'($urandom_range(8192)), last);
    endfunction

    typedef struct {
        ora_pkg::t_in_item it;
        bit fixed;
        ora_pkg::t_out_item res;
    } t_row;

    initial begin
        t_row rows[$];
        ora_pkg::t_out_item zero_res;
        ora_pkg::t_out_item sat_res;
        range_reg = ora_pkg::RANGE_RESET;
        gain_reg = ora_pkg::GAIN_RESET;
        expo_reg = ora_pkg::EXPONENT_RESET;
        sum_z_acc = 0;
        sum_x_acc = 0;
        flag_acc = 1'b0;
        zero_res = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed table
        rows.push_back('{mk(16'hFFFF, 16'h0000, 16'h1000, 1'b1), 1'b1, zero_res});
        rows.push_back('{mk(16'd8192, 16'h4000, 16'h1000, 1'b1), 1'b1, zero_res});
        rows.push_back('{mk(16'd4096, 16'h0000, 16'h1000, 1'b1), 1'b0, zero_res});
        rows.push_back('{mk(16'd3000, 16'h8000, 16'hFFFF, 1'b0), 1'b0, zero_res});
        rows.push_back('{mk(16'd5000, 16'h7FFF, 16'h0000, 1'b1), 1'b0, zero_res});
        rows.push_back('{mk(16'd2000, 16'hC000, 16'h2000, 1'b0), 1'b0, zero_res});
        rows.push_back('{mk(16'd6000, 16'h2000, 16'h3000, 1'b1), 1'b0, zero_res});
        rows.push_back('{mk(16'd1, 16'h1234, 16'h1000, 1'b1), 1'b0, zero_res});
        rows.push_back('{mk(16'd0, 16'hA5A5, 16'hFFFF, 1'b1), 1'b0, zero_res});
        rows.push_back('{mk(16'd100, 16'h0000, 16'hFFFF, 1'b0), 1'b0, zero_res});
        rows.push_back('{mk(16'd100, 16'h0000, 16'hFFFF, 1'b1), 1'b0, zero_res});
        foreach (rows[i]) send_reading(rows[i].it, rows[i].fixed, rows[i].res);
        drain_all();

        // extremes of the registers
        write_reg(ora_pkg::CFG_RANGE, 16'hFFFF);
        write_reg(ora_pkg::CFG_GAIN, 16'hFFFF);
        write_reg(ora_pkg::CFG_EXPONENT, 16'd7);
        rows = {};
        rows.push_back('{mk(16'd0, 16'h0000, 16'hFFFF, 1'b1), 1'b0, zero_res});
        rows.push_back('{mk(16'h7000, 16'h6000, 16'hFFFF, 1'b1), 1'b0, zero_res});
        rows.push_back('{mk(16'hFFFF, 16'hFFFF, 16'h0001, 1'b1), 1'b0, zero_res});
        foreach (rows[i]) send_reading(rows[i].it, rows[i].fixed, rows[i].res);
        drain_all();
        write_reg(ora_pkg::CFG_RANGE, 16'd0);
        write_reg(ora_pkg::CFG_GAIN, 16'd0);
        write_reg(ora_pkg::CFG_EXPONENT, 16'd0);
        sat_res = '0;
        send_reading(mk(16'd0, 16'h4000, 16'h1000, 1'b1), 1'b0, sat_res);
        send_reading(mk(16'd1, 16'h4000, 16'h1000, 1'b1), 1'b1, zero_res);
        drain_all();
        write_reg(ora_pkg::CFG_RANGE, 16'd1);
        write_reg(ora_pkg::CFG_GAIN, 16'd1);
        send_reading(mk(16'd1, 16'h4000, 16'h1000, 1'b1), 1'b0, zero_res);
        drain_all();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(ora_pkg::CFG_RANGE, (ph % 3 == 0) ? 16'($urandom_range(65535, 1))
                                                        : 16'($urandom_range(16384, 2048)));
            write_reg(ora_pkg::CFG_GAIN, (ph == 5) ? 16'hFFFF : 16'($urandom_range(1024)));
            write_reg(ora_pkg::CFG_EXPONENT, 16'($urandom_range(4)));
            idle_free = (ph == 2);
            if (ph == 4) begin
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < N_RANDOM / 8; k++) begin
                send_reading(random_reading($urandom_range(3) == 0), 1'b0, zero_res);
                if (k == 20 && ph == 1)
                    while (scan_results.size() != 0) @(posedge i_clk);
            end
            send_reading(random_reading(1'b1), 1'b0, zero_res);
            drain_all();
        end
        idle_free = 1'b0;

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: files.f
src/ora_pkg.sv
src/obstacle_repulsion_accumulator_core.sv
tb/obstacle_repulsion_accumulator_core_tb.sv
